[rtl/tsmc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers of the two-side move clock.
package tsmc_pkg;

	localparam int CMD_W  = 3;
	localparam int ELAP_W = 16;
	localparam int SEC_W  = 12;
	localparam int MS_W   = 22;
	localparam int TO_W   = 2;

	localparam int MS_PER_SEC = 1000;

	// floor(y / 125) = (y * RECIP_125) >> RECIP_SHIFT, exact for y < 2**19
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 26;
	localparam logic [RECIP_W-1:0] RECIP_125 = 20'd536871;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_SWITCH = 3'd2,
		CMD_UNDO   = 3'd3,
		CMD_STOP   = 3'd4
	} cmd_t;

	typedef enum logic {
		REG_MOVE_LIMIT = 1'b0,
		REG_SIDE_LIMIT = 1'b1
	} reg_idx_t;

	localparam logic [TO_W-1:0] TO_NONE  = 2'd0;
	localparam logic [TO_W-1:0] TO_RED   = 2'd1;
	localparam logic [TO_W-1:0] TO_BLACK = 2'd2;

	localparam logic [SEC_W-1:0] MOVE_LIMIT_RST = 12'd60;
	localparam logic [SEC_W-1:0] SIDE_LIMIT_RST = 12'd600;
	localparam logic [MS_W-1:0]  MOVE_MS_RST    = 22'd60000;
	localparam logic [MS_W-1:0]  SIDE_MS_RST    = 22'd600000;

	// one history snapshot
	typedef struct packed {
		logic [MS_W-1:0] red_ms;
		logic [MS_W-1:0] black_ms;
		logic [MS_W-1:0] move_ms;
		logic            side;
	} snap_t;

	// whole seconds to milliseconds
	function automatic logic [MS_W-1:0] ms_of(input logic [SEC_W-1:0] s);
		return MS_W'(s) * MS_W'(MS_PER_SEC);
	endfunction

	// milliseconds to seconds, rounded up; /1000 as >>3 then reciprocal of 125
	function automatic logic [SEC_W-1:0] sec_up(input logic [MS_W-1:0] ms);
		logic [MS_W-1:0]             x;
		logic [MS_W-4:0]             y;
		logic [MS_W-3+RECIP_W-1:0]   p;
		x = ms + MS_W'(MS_PER_SEC - 1);
		y = x[MS_W-1:3];
		p = (MS_W-3+RECIP_W)'(y) * (MS_W-3+RECIP_W)'(RECIP_125);
		return p[RECIP_SHIFT+SEC_W-1:RECIP_SHIFT];
	endfunction

endpackage

[rtl/tsmc_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: command beats, result beats and register writes.
interface tsmc_item_if;
	import tsmc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic              next_side;
	logic [ELAP_W-1:0] elapsed_ms;
	modport source (output valid, cmd, next_side, elapsed_ms, input ready);
	modport sink (input valid, cmd, next_side, elapsed_ms, output ready);
endinterface

interface tsmc_result_if;
	import tsmc_pkg::*;
	logic             valid;
	logic             ready;
	logic [TO_W-1:0]  timeout_side;
	logic             undo_ok;
	logic             clock_running;
	logic             active_side;
	logic [SEC_W-1:0] move_seconds_left;
	logic [SEC_W-1:0] red_seconds_left;
	logic [SEC_W-1:0] black_seconds_left;
	modport source (output valid, timeout_side, undo_ok, clock_running, active_side,
		move_seconds_left, red_seconds_left, black_seconds_left, input ready);
	modport sink (input valid, timeout_side, undo_ok, clock_running, active_side,
		move_seconds_left, red_seconds_left, black_seconds_left, output ready);
endinterface

interface tsmc_cfg_if;
	import tsmc_pkg::*;
	logic             valid;
	logic             ready;
	logic             index;
	logic [SEC_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/tsmc_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM, one write and one registered read port.
module tsmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/tsmc_hist.sv]
`timescale 1ns / 1ps
// Snapshot history ring: pointers, snapshot memory and write-to-read bypass.
module tsmc_hist #(
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   acc,
	input  logic [tsmc_pkg::CMD_W-1:0] acc_cmd,
	output logic [AW-1:0]          slot,
	output logic                   nonempty,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  tsmc_pkg::snap_t        wr_data,
	output tsmc_pkg::snap_t        rd_data
);
	import tsmc_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [AW-1:0] top_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] up, dn;
	logic          rd_en;
	logic          fwd_q;
	snap_t         fwd_data_q;
	snap_t         ram_q;

	assign up       = (top_q == LAST) ? '0 : top_q + 1'b1;
	assign dn       = (top_q == '0) ? LAST : top_q - 1'b1;
	assign nonempty = (count_q != '0);
	assign slot     = (acc_cmd == CMD_SWITCH) ? top_q : dn;
	assign rd_en    = acc && (acc_cmd == CMD_UNDO) && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			count_q <= '0;
		end else if (acc) begin
			unique case (cmd_t'(acc_cmd))
				CMD_START: begin
					top_q   <= '0;
					count_q <= '0;
				end
				CMD_SWITCH: begin
					top_q <= up;
					if (count_q != FULL) begin
						count_q <= count_q + 1'b1;
					end
				end
				CMD_UNDO: begin
					if (nonempty) begin
						top_q   <= dn;
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// a snapshot written in the same cycle as the read of its slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == slot);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	tsmc_ram #(
		.WIDTH ($bits(snap_t)),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (slot),
		.rdata (ram_q)
	);

	assign rd_data = fwd_q ? fwd_data_q : ram_q;
endmodule

[rtl/two_side_move_clock.sv]
`timescale 1ns / 1ps
// Two-side game clock: move and side countdowns with an undo history ring.
// A command beat is registered in stage 1, then its result in the result register.
// Throughput: one command per cycle unless the result sink stalls; the undo read of
// the history RAM is issued at accept; a same-slot write in that cycle is bypassed.
// Reset: limits 60 s / 600 s, times loaded from them, red active, clock stopped,
// history empty; the history RAM itself is never cleared, the count guards it.
module two_side_move_clock #(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	tsmc_item_if.sink     item,
	tsmc_result_if.source result,
	tsmc_cfg_if.sink      cfg
);
	import tsmc_pkg::*;

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	// configuration registers, taken by start only
	logic [SEC_W-1:0] move_lim_q, side_lim_q;

	// clock state
	logic [MS_W-1:0] red_q, black_q, move_q, reload_q;
	logic            side_q, run_q;

	// stage 1: accepted command, history read in flight
	logic              vld_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic              next_s1;
	logic [ELAP_W-1:0] elap_s1;
	logic [AW-1:0]     slot_s1;
	logic              hit_s1;

	// stage 2: result register
	logic             out_vld_q;
	logic [TO_W-1:0]  to_q;
	logic             uok_q, run_o_q, side_o_q;
	logic [MS_W-1:0]  move_o_q, red_o_q, black_o_q;

	logic          acc, adv;
	logic [AW-1:0] slot;
	logic          nonempty;
	logic          wr_en;
	snap_t         wr_data, rd_data;

	// next-state values
	logic [MS_W-1:0] n_red, n_black, n_move, n_reload;
	logic            n_side, n_run, uok;
	logic [TO_W-1:0] to;

	// register writes never stall
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_lim_q <= MOVE_LIMIT_RST;
			side_lim_q <= SIDE_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_MOVE_LIMIT: move_lim_q <= cfg.data;
				REG_SIDE_LIMIT: side_lim_q <= cfg.data;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register is free or drains
	assign adv        = vld_s1 && (!out_vld_q || result.ready);
	assign item.ready = !vld_s1 || adv;
	assign acc        = item.valid && item.ready;

	tsmc_hist #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.acc_cmd  (item.cmd),
		.slot     (slot),
		.nonempty (nonempty),
		.wr_en    (wr_en),
		.wr_addr  (slot_s1),
		.wr_data  (wr_data),
		.rd_data  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= item.cmd;
			next_s1 <= item.next_side;
			elap_s1 <= item.elapsed_ms;
			slot_s1 <= slot;
			hit_s1  <= nonempty;
		end
	end

	// snapshot pushed by switch is the state before the switch
	assign wr_data = '{red_ms: red_q, black_ms: black_q, move_ms: move_q, side: side_q};

	always_comb begin
		logic [MS_W-1:0] elap, mv, act, act_n;
		elap     = MS_W'(elap_s1);
		mv       = (move_q > elap) ? move_q - elap : '0;
		act      = side_q ? black_q : red_q;
		act_n    = (act > elap) ? act - elap : '0;
		n_red    = red_q;
		n_black  = black_q;
		n_move   = move_q;
		n_reload = reload_q;
		n_side   = side_q;
		n_run    = run_q;
		uok      = 1'b0;
		to       = TO_NONE;
		wr_en    = 1'b0;
		unique case (cmd_t'(cmd_s1))
			CMD_TICK: begin
				if (run_q && (elap_s1 != '0)) begin
					n_move = mv;
					if (side_q) begin
						n_black = act_n;
					end else begin
						n_red = act_n;
					end
					// move timeout and side timeout both name the active side
					if ((mv == '0) || (act_n == '0)) begin
						n_run = 1'b0;
						to    = side_q ? TO_BLACK : TO_RED;
					end
				end
			end
			CMD_START: begin
				n_red    = ms_of(side_lim_q);
				n_black  = ms_of(side_lim_q);
				n_reload = ms_of(move_lim_q);
				n_move   = ms_of(move_lim_q);
				n_side   = 1'b0;
				n_run    = 1'b1;
			end
			CMD_SWITCH: begin
				wr_en  = adv;
				n_side = next_s1;
				n_move = reload_q;
				n_run  = 1'b1;
			end
			CMD_UNDO: begin
				if (hit_s1) begin
					n_red   = rd_data.red_ms;
					n_black = rd_data.black_ms;
					n_move  = rd_data.move_ms;
					n_side  = rd_data.side;
					n_run   = 1'b1;
					uok     = 1'b1;
				end
			end
			CMD_STOP: begin
				n_run = 1'b0;
			end
			default: begin
				// unused codes leave the state alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q    <= SIDE_MS_RST;
			black_q  <= SIDE_MS_RST;
			move_q   <= MOVE_MS_RST;
			reload_q <= MOVE_MS_RST;
			side_q   <= 1'b0;
			run_q    <= 1'b0;
		end else if (adv) begin
			red_q    <= n_red;
			black_q  <= n_black;
			move_q   <= n_move;
			reload_q <= n_reload;
			side_q   <= n_side;
			run_q    <= n_run;
		end
	end

	// result register: holds a beat while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			to_q      <= to;
			uok_q     <= uok;
			run_o_q   <= n_run;
			side_o_q  <= n_side;
			move_o_q  <= n_move;
			red_o_q   <= n_red;
			black_o_q <= n_black;
		end
	end

	// seconds are rounded up straight from the registered milliseconds
	assign result.valid              = out_vld_q;
	assign result.timeout_side       = to_q;
	assign result.undo_ok            = uok_q;
	assign result.clock_running      = run_o_q;
	assign result.active_side        = side_o_q;
	assign result.move_seconds_left  = sec_up(move_o_q);
	assign result.red_seconds_left   = sec_up(red_o_q);
	assign result.black_seconds_left = sec_up(black_o_q);
endmodule
